FILE: rtl/edf_task_table_core_defines.svh
// Assertion macros for the EDF task table checker.
// No dependencies.
`ifndef EDF_TASK_TABLE_CORE_DEFINES_SVH
`define EDF_TASK_TABLE_CORE_DEFINES_SVH
// implication checked on every clock unless in reset
`define EDF_ASSERT_IMP(label, clk_s, rst_s, pre, post) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (post)) \
    else $error("edf check failed");
// next-cycle implication
`define EDF_ASSERT_NXT(label, clk_s, rst_s, pre, post) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) \
    else $error("edf check failed");
`endif

FILE: rtl/edf_pkg.sv
// Types and codes for the EDF task table.
// No dependencies.
package edf_pkg;
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LIST_OVERDUE = 2'd2;
  localparam logic [1:0] CMD_LIST_ACTIVE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [7:0]  handle;
    logic [31:0] deadline;
    logic [2:0]  kind;
    logic [31:0] start_tick;
  } entry_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic       shift_out;  // rotate toward index 0 (read-out)
    logic       insert;     // insert new entry at its sorted place
    logic       remove;     // close gap at matching position
    logic [6:0] rm_pos;     // position removed
  } cell_ctl_t;
endpackage

FILE: rtl/edf_cell.sv
// One slot of the active table chain.
// Depends on edf_pkg.
module edf_cell (
  input  logic                clk,
  input  edf_pkg::cell_ctl_t  ctl,
  input  logic [6:0]          my_pos,
  input  logic                valid,
  input  logic                ins_here,
  input  logic                ins_below,
  input  edf_pkg::entry_t     new_entry,
  input  edf_pkg::entry_t     prev_entry,
  input  edf_pkg::entry_t     next_entry,
  input  edf_pkg::entry_t     wrap_entry,
  input  logic                is_tail,
  output edf_pkg::entry_t     entry
);
  always_ff @(posedge clk) begin
    priority if (ctl.shift_out) begin
      entry <= is_tail ? wrap_entry : next_entry;
    end else if (ctl.insert && valid) begin
      if (ins_here) entry <= new_entry;
      else if (ins_below) entry <= prev_entry;
    end else if (ctl.remove && my_pos >= ctl.rm_pos) begin
      entry <= next_entry;
    end
  end
endmodule

FILE: rtl/edf_task_table_core.sv
// EDF task table top level: cell chain for the active table, ring memory
// for the overdue list, and the command sequencer. Depends on edf_pkg, edf_cell.
// Create: FIND rotates the chain (a same-kind entry drops at the head), INS inserts,
// then one result per cycle while the output is free (ST_FULL if full). Delete: FIND,
// one result. Lists: active likewise, overdue alternates DRAIN, OVD. A new item is
// taken only when idle with the output register free; sync reset empties both tables.
module edf_task_table_core #(
  parameter int ACTIVE_DEPTH = 16,
  parameter int OVERDUE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: cmd[1:0], handle[9:2], deadline[41:10], kind[44:42],
  // start_tick[76:45], zero fill
  input  logic [79:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: status[1:0], handle_res[9:2], deadline_res[41:10],
  // kind_res[44:42], start_tick_res[76:45], priority_res[81:77],
  // overdue_dropped[82], zero fill
  output logic [87:0]  m_tdata,
  output logic         m_tlast
);
  localparam int AW = $clog2(ACTIVE_DEPTH + 1);
  localparam int OW = $clog2(OVERDUE_DEPTH);
  localparam int OCW = $clog2(OVERDUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_ACT  = 3'd3;
  localparam logic [2:0] S_OVD  = 3'd4;
  localparam logic [2:0] S_ONE  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;

  logic [2:0] state;
  logic [1:0] cmd;
  edf_pkg::entry_t cur;
  logic [AW-1:0] count, idx;
  logic [OW-1:0] ov_newest, ov_rd, ov_next, ov_prev;
  logic [OCW-1:0] ov_count, ov_idx;
  logic dropped;
  logic skip_head, hit_now;
  logic found;

  edf_pkg::entry_t cells [ACTIVE_DEPTH];
  edf_pkg::entry_t ov_mem [OVERDUE_DEPTH];
  edf_pkg::entry_t ov_q;
  edf_pkg::cell_ctl_t ctl;

  // output register
  logic ob_v, ob_last;
  logic [1:0] ob_st;
  edf_pkg::entry_t ob_e;
  logic [4:0] ob_pr;
  logic ob_drop;
  logic ob_free;
  logic ob_load;
  assign ob_free = !ob_v || m_tready;
  assign ob_load = ob_free && (state == S_ACT || state == S_OVD || state == S_ONE);

  assign m_tvalid = ob_v;
  assign m_tlast = ob_last;
  assign m_tdata = {5'd0, ob_drop, ob_pr, ob_e.start_tick, ob_e.kind,
                    ob_e.deadline, ob_e.handle, ob_st};
  assign s_tready = (state == S_IDLE) && ob_free;

  assign ov_next = (ov_newest == OW'(OVERDUE_DEPTH - 1)) ? '0 : ov_newest + OW'(1);
  assign ov_prev = (ov_rd == '0) ? OW'(OVERDUE_DEPTH - 1) : ov_rd - OW'(1);

  // head of chain is cells[0]; matching test happens at the head while rotating
  logic head_hit;
  assign head_hit = (cmd == edf_pkg::CMD_CREATE) ? (cells[0].kind == cur.kind)
                                                 : (cells[0].handle == cur.handle);

  logic [AW-1:0] tail;
  logic do_emit;
  always_comb begin
    ctl = '0;
    tail = count - AW'(1);
    do_emit = 1'b0;
    unique case (state)
      S_FIND: ctl.shift_out = (idx != count);
      S_INS:  ctl.insert = 1'b1;
      S_ACT:  begin
        do_emit = ob_free;
        ctl.shift_out = ob_free;
      end
      default: ;
    endcase
  end

  // during FIND a hit drops the head (not rewrapped); tail cell then takes next
  assign hit_now = (state == S_FIND) && (idx != count) && !found && head_hit;
  assign skip_head = hit_now;

  // insertion position: count of entries with deadline < new, via per-cell flags
  logic [ACTIVE_DEPTH-1:0] lt;
  for (genvar g = 0; g < ACTIVE_DEPTH; g++) begin : g_cell
    logic v;
    assign v = (AW'(g) <= count);
    assign lt[g] = (AW'(g) < count) && (cells[g].deadline < cur.deadline);
    edf_cell u_cell (
      .clk(clk), .ctl(ctl), .my_pos(7'(g)), .valid(v),
      .ins_here((g == 0 || lt[(g == 0) ? 0 : g-1]) && !lt[g]),
      .ins_below((g != 0) && !lt[(g == 0) ? 0 : g-1]),
      .new_entry(cur),
      .prev_entry(cells[(g == 0) ? 0 : g-1]),
      .next_entry(cells[(g == ACTIVE_DEPTH-1) ? g : g+1]),
      .wrap_entry(skip_head ? cells[(g == ACTIVE_DEPTH-1) ? g : g+1] : cells[0]),
      .is_tail(AW'(g) == tail),
      .entry(cells[g]));
  end

  always_ff @(posedge clk) begin
    if (hit_now && cmd == edf_pkg::CMD_CREATE)
      ov_mem[ov_next] <= cells[0];
    ov_q <= ov_mem[ov_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; ov_newest <= '0; ov_count <= '0;
      ob_v <= 1'b0; found <= 1'b0;
    end else begin
      if (ob_load) ob_v <= 1'b1;
      else if (m_tready) ob_v <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          cmd <= s_tdata[1:0];
          cur <= '{s_tdata[9:2], s_tdata[41:10], s_tdata[44:42], s_tdata[76:45]};
          idx <= '0; found <= 1'b0; dropped <= 1'b0;
          ov_rd <= ov_newest; ov_idx <= '0;
          unique case (s_tdata[1:0])
            edf_pkg::CMD_CREATE, edf_pkg::CMD_DELETE: state <= S_FIND;
            edf_pkg::CMD_LIST_ACTIVE: state <= (count == '0) ? S_ONE : S_ACT;
            default: state <= (ov_count == '0) ? S_ONE : S_DRAIN;
          endcase
        end
        S_FIND: begin
          if (idx == count) begin
            if (cmd == edf_pkg::CMD_CREATE) begin
              if (count == AW'(ACTIVE_DEPTH)) state <= S_ONE;
              else state <= S_INS;
            end else state <= S_ONE;
          end else begin
            // a dropped head shortens the table, so the step count stays put
            if (hit_now) begin
              found <= 1'b1;
              count <= count - AW'(1);
              if (cmd == edf_pkg::CMD_DELETE) ob_e <= cells[0];
              else begin
                ov_newest <= ov_next;
                dropped <= (ov_count == OCW'(OVERDUE_DEPTH));
                if (ov_count != OCW'(OVERDUE_DEPTH)) ov_count <= ov_count + OCW'(1);
              end
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        S_INS: begin
          count <= count + AW'(1); idx <= '0; state <= S_ACT;
        end
        S_ACT: if (do_emit) begin
          ob_st <= edf_pkg::ST_OK; ob_e <= cells[0];
          ob_pr <= 5'(count - idx);
          ob_drop <= (cmd == edf_pkg::CMD_CREATE) && dropped;
          ob_last <= (idx + AW'(1) == count);
          idx <= idx + AW'(1);
          if (idx + AW'(1) == count) state <= S_IDLE;
        end
        S_DRAIN: begin
          state <= S_OVD;
        end
        S_OVD: if (ob_free) begin
          ob_st <= edf_pkg::ST_OK; ob_e <= ov_q;
          ob_pr <= '0; ob_drop <= 1'b0;
          ob_last <= (ov_idx + OCW'(1) == ov_count);
          ov_idx <= ov_idx + OCW'(1);
          ov_rd <= ov_prev;
          state <= (ov_idx + OCW'(1) == ov_count) ? S_IDLE : S_DRAIN;
        end
        S_ONE: if (ob_free) begin
          ob_pr <= '0; ob_drop <= 1'b0; ob_last <= 1'b1;
          state <= S_IDLE;
          priority if (cmd == edf_pkg::CMD_CREATE) begin
            ob_st <= edf_pkg::ST_FULL; ob_e <= '0;
          end else if (cmd == edf_pkg::CMD_DELETE) begin
            ob_st <= found ? edf_pkg::ST_OK : edf_pkg::ST_NOT_FOUND;
            if (!found) ob_e <= '0;
          end else begin
            ob_st <= edf_pkg::ST_EMPTY; ob_e <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/edf_checker.sv
// Port-level checks for edf_task_table_core, bound to the top level.
// Depends on edf_task_table_core_defines.svh.
`include "edf_task_table_core_defines.svh"
module edf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic        m_tlast
);
  `EDF_ASSERT_IMP(a_err_last, clk, rst, m_tvalid && m_tdata[1:0] != 2'd0, m_tlast)
  `EDF_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `EDF_ASSERT_NXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready)
endmodule

bind edf_task_table_core edf_checker u_edf_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast));

FILE: tb/tb_edf_task_table_core.sv
// Testbench for edf_task_table_core: drives create/delete/list commands on the
// input stream and checks every result against a deadline-ordered table model.
// Depends on edf_pkg and the edf_task_table_core RTL.
module tb_edf_task_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADEPTH = 16;
  localparam int ODEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  handle;
    logic [31:0] deadline;
    logic [2:0]  kind;
    logic [31:0] rel;
    logic [4:0]  prio;
    logic        dropped;
    logic        last;
  } result_t;

  class edf_scoreboard;
    edf_pkg::entry_t act[ADEPTH];
    edf_pkg::entry_t ovd[ODEPTH];
    int act_n;
    int ovd_n;
    int ovd_top;
    result_t pending[$];
    int errors;
    int results_seen;

    function new();
      act_n = 0;
      ovd_n = 0;
      ovd_top = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void push_res(logic [1:0] st, edf_pkg::entry_t e, logic [4:0] pr, logic dr,
                           logic lst);
      result_t r;
      r.status = st;
      r.handle = e.handle;
      r.deadline = e.deadline;
      r.kind = e.kind;
      r.rel = e.start_tick;
      r.prio = pr;
      r.dropped = dr;
      r.last = lst;
      pending.push_back(r);
    endfunction

    function void drop_at(int idx);
      for (int i = idx; i + 1 < act_n; i++) act[i] = act[i + 1];
      act_n--;
    endfunction

    function void stream_table(logic dr);
      for (int i = 0; i < act_n; i++)
        push_res(edf_pkg::ST_OK, act[i], 5'(act_n - i), dr, i + 1 == act_n);
    endfunction

    function void note_cmd(logic [1:0] cmd, edf_pkg::entry_t e);
      edf_pkg::entry_t z;
      logic dr;
      int pos;
      z = '0;
      dr = 0;
      case (cmd)
        edf_pkg::CMD_CREATE: begin
          for (int i = 0; i < act_n; i++) begin
            if (act[i].kind == e.kind) begin
              dr = ovd_n >= ODEPTH;
              ovd_top = (ovd_top + 1) % ODEPTH;
              ovd[ovd_top] = act[i];
              if (!dr) ovd_n++;
              drop_at(i);
              break;
            end
          end
          if (act_n >= ADEPTH) begin
            push_res(edf_pkg::ST_FULL, z, 0, 0, 1);
          end else begin
            pos = 0;
            while (pos < act_n && act[pos].deadline < e.deadline) pos++;
            for (int i = act_n; i > pos; i--) act[i] = act[i - 1];
            act[pos] = e;
            act_n++;
            stream_table(dr);
          end
        end
        edf_pkg::CMD_DELETE: begin
          pos = -1;
          for (int i = 0; i < act_n; i++)
            if (pos < 0 && act[i].handle == e.handle) pos = i;
          if (pos < 0) begin
            push_res(edf_pkg::ST_NOT_FOUND, z, 0, 0, 1);
          end else begin
            push_res(edf_pkg::ST_OK, act[pos], 0, 0, 1);
            drop_at(pos);
          end
        end
        edf_pkg::CMD_LIST_OVERDUE: begin
          if (ovd_n == 0) push_res(edf_pkg::ST_EMPTY, z, 0, 0, 1);
          for (int i = 0; i < ovd_n; i++)
            push_res(edf_pkg::ST_OK, ovd[(ovd_top + ODEPTH - i) % ODEPTH], 0, 0,
                     i + 1 == ovd_n);
        end
        default: begin
          if (act_n == 0) push_res(edf_pkg::ST_EMPTY, z, 0, 0, 1);
          else stream_table(0);
        end
      endcase
    endfunction

    function void check_result(logic [87:0] d, logic lst);
      result_t x;
      results_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (d[1:0] != x.status) begin
        $error("status exp %0d got %0d", x.status, d[1:0]); errors++;
      end
      if (d[9:2] != x.handle) begin
        $error("handle_res exp %0d got %0d", x.handle, d[9:2]); errors++;
      end
      if (d[41:10] != x.deadline) begin
        $error("deadline_res exp %0d got %0d", x.deadline, d[41:10]); errors++;
      end
      if (d[44:42] != x.kind) begin
        $error("kind_res exp %0d got %0d", x.kind, d[44:42]); errors++;
      end
      if (d[76:45] != x.rel) begin
        $error("start_tick_res exp %0d got %0d", x.rel, d[76:45]); errors++;
      end
      if (d[81:77] != x.prio) begin
        $error("priority_res exp %0d got %0d", x.prio, d[81:77]); errors++;
      end
      if (d[82] != x.dropped) begin
        $error("overdue_dropped exp %0d got %0d", x.dropped, d[82]); errors++;
      end
      if (d[87:83] != 0) begin
        $error("zero fill exp 0 got %0d", d[87:83]); errors++;
      end
      if (lst != x.last) begin
        $error("last exp %0d got %0d", x.last, lst); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
  logic [79:0] s_tdata;
  logic [87:0] m_tdata;

  edf_task_table_core #(.ACTIVE_DEPTH(ADEPTH), .OVERDUE_DEPTH(ODEPTH)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  edf_scoreboard sb = new();
  int send_idle_pct, recv_idle_pct;
  bit hold_recv;
  int cycles;
  int cmd_tally[4];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
      m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // tvalid stays high across back-to-back items unless an idle gap is drawn; callers drop it when done
  task automatic send_cmd(logic [1:0] cmd, logic [7:0] h, logic [31:0] dl,
                          logic [2:0] k, logic [31:0] rel);
    edf_pkg::entry_t e;
    e.handle = h;
    e.deadline = dl;
    e.kind = k;
    e.start_tick = rel;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {3'b0, rel, k, dl, h, cmd};
    do @(posedge clk); while (!s_tready);
    sb.note_cmd(cmd, e);
    cmd_tally[cmd]++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_cmd();
    int r;
    logic [31:0] dl;
    r = $urandom_range(99);
    dl = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom();
    if (r < 50)
      send_cmd(edf_pkg::CMD_CREATE, 8'($urandom_range(31)), dl, 3'($urandom_range(7)),
               $urandom());
    else if (r < 70)
      send_cmd(edf_pkg::CMD_DELETE,
               ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(31)),
               32'd0, 3'd0, 32'd0);
    else if (r < 85)
      send_cmd(edf_pkg::CMD_LIST_OVERDUE, 8'($urandom()), $urandom(), 3'($urandom()),
               $urandom());
    else
      send_cmd(edf_pkg::CMD_LIST_ACTIVE, 8'($urandom()), $urandom(), 3'($urandom()),
               $urandom());
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    hold_recv = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty lists, missing delete, extremes, ties, same-kind replace
    send_cmd(edf_pkg::CMD_LIST_ACTIVE, 8'd0, 32'd0, 3'd0, 32'd0);
    send_cmd(edf_pkg::CMD_LIST_OVERDUE, 8'hff, '1, 3'h7, '1);
    send_cmd(edf_pkg::CMD_DELETE, 8'h00, 32'd0, 3'd0, 32'd0);
    send_cmd(edf_pkg::CMD_CREATE, 8'h00, 32'h0, 3'd0, 32'h0);
    send_cmd(edf_pkg::CMD_CREATE, 8'hff, 32'hffff_ffff, 3'd7, 32'hffff_ffff);
    send_cmd(edf_pkg::CMD_CREATE, 8'h55, 32'h0, 3'd1, 32'haaaa_5555);
    send_cmd(edf_pkg::CMD_CREATE, 8'h55, 32'h0, 3'd1, 32'h1234_5678);
    send_cmd(edf_pkg::CMD_LIST_OVERDUE, 8'd0, 32'd0, 3'd0, 32'd0);
    send_cmd(edf_pkg::CMD_DELETE, 8'h55, 32'd0, 3'd0, 32'd0);
    send_cmd(edf_pkg::CMD_DELETE, 8'h55, 32'd0, 3'd0, 32'd0);
    send_cmd(edf_pkg::CMD_LIST_ACTIVE, 8'd0, 32'd0, 3'd0, 32'd0);
    // one create per kind, replacing what is there
    for (int i = 0; i < 8; i++)
      send_cmd(edf_pkg::CMD_CREATE, 8'(i), 32'(100 - i), 3'(i), 32'(i));
    drain();
    for (int i = 0; i < 20; i++) random_cmd();
    drain();

    // pressure: hold the receiver while commands keep coming
    hold_recv = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_recv = 0;
      end
      begin
        for (int i = 0; i < 6; i++) random_cmd();
        s_tvalid <= 0;
      end
    join
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 87 : 0;
      recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 14 : 0;
      for (int i = 0; i < 85; i++) random_cmd();
      drain();
    end

    $display("commands: %0d create, %0d delete, %0d overdue lists, %0d active lists",
             cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3]);
    $display("%0d results checked, %0d mismatches", sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/edf_pkg.sv
rtl/edf_cell.sv
rtl/edf_task_table_core.sv
rtl/edf_checker.sv
tb/tb_edf_task_table_core.sv
